// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hsm_pkg.sv =====
// ---------------------------------------------------------------------------
// hsm_pkg
// Types, codes and constants of the heartbeat and stall monitor.
// ---------------------------------------------------------------------------
package hsm_pkg;

  // default number of heartbeat slots
  localparam int SLOTS_DEF = 4;

  localparam logic [3:0]  DEF_STALL_LIMIT = 4'd3;
  localparam logic [31:0] DEF_STALE_MS    = 32'd15000;
  localparam logic [9:0]  US_PER_MS       = 10'd1000;
  localparam logic [3:0]  CNT_MAX         = 4'hF;

  // limit in microseconds: 32-bit ms times 1000
  localparam int LIM_US_W = 42;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_KICK = 2'd1,
    CMD_ARM  = 2'd2,
    CMD_SET  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REASON_NONE  = 2'd0,
    REASON_STALL = 2'd1,
    REASON_STALE = 2'd2
  } reason_e;

  typedef enum logic [1:0] {
    CFG_STALL_LIMIT = 2'd0,
    CFG_STALE_FLOOR = 2'd1,
    CFG_SAMPLE_EN   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DONE
  } state_t;

  // input word
  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  slot;
    logic [62:0] now_us;
    logic [31:0] sample_count;
    logic [31:0] stale_limit_ms;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        reboot_request;
    logic [1:0]  reboot_reason;
    logic [1:0]  stale_slot;
    logic [3:0]  stall_count;
  } out_word_t;

  // configuration registers
  typedef struct packed {
    logic [3:0]  stall_limit;
    logic [31:0] stale_floor_ms;
    logic        sample_check_enable;
  } cfg_t;

  // slot bank write request
  typedef struct packed {
    logic        kick;
    logic        set;
    logic [1:0]  slot;
    logic [62:0] stamp;
    logic [31:0] limit;
  } bank_wr_t;

  // age comparator result
  typedef struct packed {
    logic valid;
    logic stale;
  } age_res_t;

endpackage

// ===== src/hsm_slot_bank.sv =====
// ---------------------------------------------------------------------------
// hsm_slot_bank
// Per-slot kick stamps and stale limits, one write and one read per cycle.
// ---------------------------------------------------------------------------
module hsm_slot_bank
  import hsm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  bank_wr_t       wr,
  input  logic [SIW-1:0] rd_idx,
  output logic [62:0]    rd_stamp,
  output logic [31:0]    rd_limit
);

  logic [62:0]    stamp [SLOTS];
  logic [31:0]    limit [SLOTS];
  logic           in_range;
  logic [SIW-1:0] wr_idx;

  // slot numbers at or above SLOTS are dropped
  assign in_range = (32'(wr.slot) < 32'(SLOTS));
  assign wr_idx   = SIW'(wr.slot);

  // stamp and limit storage; slot 0 starts with the default limit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        stamp[i] <= '0;
        limit[i] <= (i == 0) ? DEF_STALE_MS : '0;
      end
    end else begin
      if (wr.kick && in_range) stamp[wr_idx] <= wr.stamp;
      if (wr.set && in_range)  limit[wr_idx] <= wr.limit;
    end
  end

  assign rd_stamp = stamp[rd_idx];
  assign rd_limit = limit[rd_idx];

endmodule

// ===== src/hsm_age_unit.sv =====
// ---------------------------------------------------------------------------
// hsm_age_unit
// Shared two-stage age comparator: is now - stamp above limit * 1000 us?
// ---------------------------------------------------------------------------
module hsm_age_unit
  import hsm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           issue,
  input  logic [SIW-1:0] idx,
  input  logic [62:0]    now_us,
  input  logic [62:0]    stamp,
  input  logic [31:0]    limit,
  output age_res_t       res,
  output logic [SIW-1:0] res_idx
);

  logic [63:0]         diff;
  logic                live;
  logic [LIM_US_W-1:0] lim_us_c;

  logic                v_r;
  logic                live_r;
  logic [62:0]         age_r;
  logic [LIM_US_W-1:0] lim_us_r;
  logic [SIW-1:0]      idx_r;

  // stage 1: age by subtraction, limit scaled to microseconds
  assign diff     = {1'b0, now_us} - {1'b0, stamp};
  assign live     = (stamp != '0) && !diff[63] && (diff[62:0] != '0);
  assign lim_us_c = LIM_US_W'(limit) * LIM_US_W'(US_PER_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
    end else begin
      v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    live_r   <= live;
    age_r    <= diff[62:0];
    lim_us_r <= lim_us_c;
    idx_r    <= idx;
  end

  // stage 2: compare against the limit
  assign res.valid = v_r;
  assign res.stale = live_r && (age_r > 63'(lim_us_r));
  assign res_idx   = idx_r;

endmodule

// ===== src/hsm_seq.sv =====
// ---------------------------------------------------------------------------
// hsm_seq
// Command sequencer: stall check state, slot walk control, result register.
// ---------------------------------------------------------------------------
module hsm_seq
  import hsm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  in_word_t       in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output out_word_t      out_data,
  input  cfg_t           cfg,
  output bank_wr_t       bank_wr,
  output logic [SIW-1:0] rd_idx,
  output logic           issue,
  output logic [62:0]    age_now,
  input  age_res_t       res,
  input  logic [SIW-1:0] res_idx
);

  localparam int CW = SIW + 1;

  state_t         state;
  state_t         state_next;
  in_word_t       item;
  logic           armed;
  logic           baseline_taken;
  logic [31:0]    last_sample_count;
  logic [3:0]     stall_counter;
  logic           res_req;
  logic [1:0]     res_reason;
  logic [SIW-1:0] res_slot;
  logic [CW-1:0]  iss;

  logic           accept;
  logic           exec;
  logic           load_out;
  logic           tick_live;
  logic           walk_hit;
  logic           walk_end;
  logic [3:0]     cnt_inc;
  logic           same;
  logic           stalled;
  logic [3:0]     cnt_next;

  // sample stall check, evaluated in the execute cycle
  assign same     = (item.sample_count == last_sample_count);
  assign cnt_inc  = (stall_counter == CNT_MAX) ? CNT_MAX : stall_counter + 4'd1;
  assign stalled  = cfg.sample_check_enable && baseline_taken && same &&
                    (cnt_inc >= cfg.stall_limit);
  always_comb begin
    cnt_next = stall_counter;
    if (cfg.sample_check_enable && baseline_taken) begin
      cnt_next = same ? cnt_inc : 4'd0;
    end
  end

  assign tick_live = (item.command == CMD_TICK) && armed;
  assign walk_hit  = res.valid && res.stale;
  assign walk_end  = (iss == CW'(SLOTS)) && !res.valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = (tick_live && !stalled) ? ST_WALK : ST_DONE;
      ST_WALK: if (walk_hit || walk_end) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    exec     = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: exec = 1'b1;
      ST_WALK: issue = (iss < CW'(SLOTS));
      ST_DONE: load_out = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept  = in_valid && !in_stall;
  assign rd_idx  = SIW'(iss);
  assign age_now = item.now_us;

  // slot bank writes for kick, arm and set
  always_comb begin
    bank_wr       = '0;
    bank_wr.slot  = item.slot;
    bank_wr.stamp = item.now_us;
    bank_wr.limit = (item.stale_limit_ms < cfg.stale_floor_ms) ?
                    cfg.stale_floor_ms : item.stale_limit_ms;
    bank_wr.kick  = exec && ((item.command == CMD_KICK) || (item.command == CMD_ARM));
    bank_wr.set   = exec && (item.command == CMD_SET);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      armed             <= 1'b0;
      baseline_taken    <= 1'b0;
      last_sample_count <= '0;
      stall_counter     <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (exec && (item.command == CMD_ARM)) armed <= 1'b1;
      if (exec && tick_live && cfg.sample_check_enable) begin
        baseline_taken    <= 1'b1;
        last_sample_count <= item.sample_count;
        stall_counter     <= cnt_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, walk and result registers
  always_ff @(posedge clk) begin
    if (accept) item <= in_data;
    if (exec) begin
      iss        <= '0;
      res_req    <= tick_live && stalled;
      res_reason <= (tick_live && stalled) ? REASON_STALL : REASON_NONE;
      res_slot   <= '0;
    end else if (state == ST_WALK) begin
      if (issue) iss <= iss + CW'(1);
      if (walk_hit) begin
        res_req    <= 1'b1;
        res_reason <= REASON_STALE;
        res_slot   <= res_idx;
      end
    end
    if (load_out) begin
      out_data.reboot_request <= res_req;
      out_data.reboot_reason  <= res_reason;
      out_data.stale_slot     <= 2'(res_slot);
      out_data.stall_count    <= stall_counter;
    end
  end

endmodule

// ===== src/heartbeat_stall_monitor.sv =====
// ---------------------------------------------------------------------------
// heartbeat_stall_monitor
// Heartbeat and sample counter stall monitor with reboot requests.
// ---------------------------------------------------------------------------
// One word in, one result word out. Kick, arm and set-limit words pass from
// acceptance through the execute and done states back to idle. An armed tick
// that finds no stall walks the slots through the single age comparator, one
// per cycle through its two stages; the walk stops at the first stale slot. A
// tick that finds a stall skips the walk. The input is stalled while a word is
// in work; a finished result waits in the output register without blocking
// acceptance, and a following result holds the sequencer, and so the input,
// for as long as that register stays stalled.
`include "assert_macros.svh"

module heartbeat_stall_monitor
  import hsm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cfg_t           cfg;
  bank_wr_t       bank_wr;
  logic [SIW-1:0] rd_idx;
  logic [62:0]    rd_stamp;
  logic [31:0]    rd_limit;
  logic           issue;
  logic [62:0]    age_now;
  age_res_t       res;
  logic [SIW-1:0] res_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_limit         <= DEF_STALL_LIMIT;
      cfg.stale_floor_ms      <= DEF_STALE_MS;
      cfg.sample_check_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STALL_LIMIT: cfg.stall_limit         <= cfg_data[3:0];
        CFG_STALE_FLOOR: cfg.stale_floor_ms      <= cfg_data;
        CFG_SAMPLE_EN:   cfg.sample_check_enable <= cfg_data[0];
        default:         cfg.stall_limit         <= cfg.stall_limit;
      endcase
    end
  end

  hsm_seq #(.SLOTS(SLOTS), .SIW(SIW)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg),
    .bank_wr   (bank_wr),
    .rd_idx    (rd_idx),
    .issue     (issue),
    .age_now   (age_now),
    .res       (res),
    .res_idx   (res_idx)
  );

  hsm_slot_bank #(.SLOTS(SLOTS), .SIW(SIW)) u_bank (
    .clk      (clk),
    .rst      (rst),
    .wr       (bank_wr),
    .rd_idx   (rd_idx),
    .rd_stamp (rd_stamp),
    .rd_limit (rd_limit)
  );

  hsm_age_unit #(.SLOTS(SLOTS), .SIW(SIW)) u_age (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .idx     (rd_idx),
    .now_us  (age_now),
    .stamp   (rd_stamp),
    .limit   (rd_limit),
    .res     (res),
    .res_idx (res_idx)
  );

  // checks
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
    "input not stalled after accept")
  `ASSERT_ALWAYS(a_reason_req, clk, rst,
    !out_valid || ((out_data.reboot_reason == REASON_NONE) == !out_data.reboot_request),
    "reason and request disagree")
  `ASSERT_ALWAYS(a_slot_only_stale, clk, rst,
    !out_valid || out_data.stale_slot == 2'd0 || out_data.reboot_reason == REASON_STALE,
    "stale slot without stale reason")
  `ASSERT_ALWAYS(a_stall_limit, clk, rst,
    !out_valid || out_data.reboot_reason != REASON_STALL ||
      out_data.stall_count >= cfg.stall_limit,
    "stall reported below limit")

endmodule

// ===== test/heartbeat_stall_monitor_test.sv =====
// ---------------------------------------------------------------------------
// heartbeat_stall_monitor_test
// Self-checking bench for the heartbeat and stall monitor. A short scripted
// run covers field extremes, every command and the corner cases of the tick
// logic. Randomised traffic follows under several register settings, each
// result word checked against a behavioural predictor held in the bench.
// ---------------------------------------------------------------------------
module heartbeat_stall_monitor_test;
  import hsm_pkg::*;

  localparam int          PHASE_WORDS = 320;
  localparam int          QUIET_LIMIT = 2000;
  localparam logic [62:0] T_MAX       = 63'h7FFF_FFFF_FFFF_FFFF;

  // one scripted word, with an optional hand-written result
  typedef struct packed {
    logic      typed;
    out_word_t want;
    in_word_t  w;
  } row_t;

  localparam out_word_t QUIET = '{1'b0, REASON_NONE, 2'd0, 4'd0};

  localparam row_t SCRIPT [21] = '{
    // tick before arm, kick to zero, set below floor and at the top, then arm
    '{1'b1, QUIET, '{CMD_TICK, 2'd0, 63'd5, 32'd7, 32'd0}},
    '{1'b1, QUIET, '{CMD_KICK, 2'd1, 63'd0, 32'd0, 32'd0}},
    '{1'b1, QUIET, '{CMD_SET, 2'd3, 63'd0, 32'd0, 32'd0}},
    '{1'b1, QUIET, '{CMD_SET, 2'd2, 63'd0, 32'd0, 32'hFFFF_FFFF}},
    '{1'b1, QUIET, '{CMD_ARM, 2'd0, 63'd1000, 32'd0, 32'd0}},
    // baseline, then an unchanged count until the limit and beyond
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd2000, 32'd10, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd3000, 32'd10, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd4000, 32'd10, 32'd0}},
    '{1'b1, '{1'b1, REASON_STALL, 2'd0, 4'd3},
            '{CMD_TICK, 2'd0, 63'd5000, 32'd10, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd6000, 32'd10, 32'd0}},
    // age exactly at the limit, then one microsecond past it
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd15_001_000, 32'd11, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd15_001_001, 32'd12, 32'd0}},
    // stamp in the future, zero limit slot, time at the top
    '{1'b0, QUIET, '{CMD_KICK, 2'd0, T_MAX, 32'd0, 32'd0}},
    '{1'b0, QUIET, '{CMD_KICK, 2'd1, 63'd1, 32'd0, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd2, 32'd0, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd3, T_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    // unarm slot 1, the highest slot goes stale behind unarmed and future slots
    '{1'b0, QUIET, '{CMD_KICK, 2'd1, 63'd0, 32'd0, 32'd0}},
    '{1'b0, QUIET, '{CMD_KICK, 2'd3, 63'd7, 32'd0, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, 63'd15_000_008, 32'hFFFF_FFFF, 32'd0}},
    '{1'b0, QUIET, '{CMD_ARM, 2'd2, 63'd100, 32'd0, 32'd0}},
    '{1'b0, QUIET, '{CMD_TICK, 2'd0, T_MAX, 32'd1, 32'd0}}
  };

  // register settings per random phase; phase 3 runs with no idling
  localparam cfg_t PLANS [6] = '{
    '{4'd15, 32'd0, 1'b1},
    '{4'd0, 32'hFFFF_FFFF, 1'b1},
    '{4'd1, 32'd15000, 1'b0},
    '{4'd3, 32'd15000, 1'b1},
    '{4'd2, 32'd500, 1'b1},
    '{4'd7, 32'd20000, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the monitor state and registers
  logic        mon_armed;
  logic        mon_base;
  logic [31:0] mon_last;
  logic [3:0]  mon_stalls;
  logic [62:0] kick_at [SLOTS_DEF];
  logic [31:0] limit_ms [SLOTS_DEF];
  logic [3:0]  lim_stall;
  logic [31:0] floor_ms;
  logic        chk_en;

  // random traffic state
  logic [62:0] clock_us = 63'd20_000_000;
  logic [31:0] last_fed = '0;
  int          stuck_left = 0;

  out_word_t   verdicts_due [$];
  logic        steady = 1'b0;
  int          faults = 0;
  int          quiet_run = 0;

  heartbeat_stall_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predict the result word of one accepted word and advance the state
  function automatic out_word_t judge_word(input in_word_t w);
    out_word_t   r;
    logic        stalled;
    logic [63:0] age;
    logic [63:0] allow;
    r = '0;
    stalled = 1'b0;
    case (cmd_e'(w.command))
      CMD_TICK: begin
        if (mon_armed) begin
          if (chk_en) begin
            if (!mon_base) begin
              mon_base = 1'b1;
            end else if (w.sample_count == mon_last) begin
              if (mon_stalls != CNT_MAX) mon_stalls = mon_stalls + 4'd1;
              if (mon_stalls >= lim_stall) stalled = 1'b1;
            end else begin
              mon_stalls = '0;
            end
            mon_last = w.sample_count;
          end
          if (stalled) begin
            r.reboot_request = 1'b1;
            r.reboot_reason  = REASON_STALL;
          end else begin
            // lowest armed slot past its limit wins
            for (int i = 0; i < SLOTS_DEF; i++) begin
              if (!r.reboot_request && kick_at[i] != '0 && w.now_us > kick_at[i]) begin
                age   = 64'(w.now_us - kick_at[i]);
                allow = 64'(limit_ms[i]) * 64'(US_PER_MS);
                if (age > allow) begin
                  r.reboot_request = 1'b1;
                  r.reboot_reason  = REASON_STALE;
                  r.stale_slot     = 2'(i);
                end
              end
            end
          end
        end
      end
      CMD_KICK: kick_at[w.slot] = w.now_us;
      CMD_ARM: begin
        kick_at[w.slot] = w.now_us;
        mon_armed = 1'b1;
      end
      default: limit_ms[w.slot] = (w.stale_limit_ms < floor_ms) ? floor_ms : w.stale_limit_ms;
    endcase
    r.stall_count = mon_stalls;
    return r;
  endfunction

  // draw one random word: time mostly moves forward, counts often stick
  function automatic in_word_t next_event();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    w.command = pick < 50 ? CMD_TICK : pick < 75 ? CMD_KICK : pick < 83 ? CMD_ARM : CMD_SET;
    w.slot = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 70) clock_us = clock_us + 63'($urandom_range(0, 3_000_000));
    else if (pick < 90) clock_us = clock_us + 63'($urandom_range(0, 40_000_000));
    else if (pick < 95) clock_us = 63'({$urandom(), $urandom()});
    else clock_us = clock_us - 63'($urandom_range(0, 2_000_000));
    w.now_us = ($urandom_range(0, 99) < 3) ? '0 : clock_us;
    w.sample_count = $urandom();
    if (w.command == CMD_TICK) begin
      if (stuck_left == 0 && $urandom_range(0, 99) < 4) stuck_left = $urandom_range(8, 24);
      pick = $urandom_range(0, 99);
      if (stuck_left > 0 || pick < 45) begin
        w.sample_count = last_fed;
        if (stuck_left > 0) stuck_left--;
      end else if (pick < 90) begin
        w.sample_count = last_fed + 32'($urandom_range(1, 50));
      end
      last_fed = w.sample_count;
    end
    pick = $urandom_range(0, 99);
    w.stale_limit_ms = pick < 60 ? 32'($urandom_range(0, 30000)) :
                       pick < 80 ? 32'($urandom_range(0, 200)) : $urandom();
    return w;
  endfunction

  // offer one word, with an occasional gap first, and log its result
  task automatic present(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t calc;
    int        gap;
    gap = (!steady && $urandom_range(0, 99) < 8) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    calc = judge_word(w);
    verdicts_due.push_back(typed ? want : calc);
    // withdraw the word once taken
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // hold off the sender until every result word is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STALL_LIMIT: lim_stall = val[3:0];
      CFG_STALE_FLOOR: floor_ms = val;
      default:         chk_en = val[0];
    endcase
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 8);
  end

  // result checker
  always @(posedge clk) begin
    out_word_t due;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result word with nothing outstanding: %h", out_data);
        faults++;
      end else begin
        due = verdicts_due.pop_front();
        if (out_data.reboot_request !== due.reboot_request) begin
          $error("reboot_request: expected %0d, got %0d",
                 due.reboot_request, out_data.reboot_request);
          faults++;
        end
        if (out_data.reboot_reason !== due.reboot_reason) begin
          $error("reboot_reason: expected %0d, got %0d",
                 due.reboot_reason, out_data.reboot_reason);
          faults++;
        end
        if (out_data.stale_slot !== due.stale_slot) begin
          $error("stale_slot: expected %0d, got %0d", due.stale_slot, out_data.stale_slot);
          faults++;
        end
        if (out_data.stall_count !== due.stall_count) begin
          $error("stall_count: expected %0d, got %0d", due.stall_count, out_data.stall_count);
          faults++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_run <= 0;
    end else if (quiet_run == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_run <= quiet_run + 1;
    end
  end

  initial begin
    mon_armed  = 1'b0;
    mon_base   = 1'b0;
    mon_last   = '0;
    mon_stalls = '0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      kick_at[i]  = '0;
      limit_ms[i] = '0;
    end
    limit_ms[0] = DEF_STALE_MS;
    lim_stall   = DEF_STALL_LIMIT;
    floor_ms    = DEF_STALE_MS;
    chk_en      = 1'b1;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // scripted part under reset register values
    foreach (SCRIPT[k]) present(SCRIPT[k].w, SCRIPT[k].typed, SCRIPT[k].want);

    // random phases, registers changed only once drained
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(CFG_STALL_LIMIT, 32'(PLANS[p].stall_limit));
      write_reg(CFG_STALE_FLOOR, PLANS[p].stale_floor_ms);
      write_reg(CFG_SAMPLE_EN, 32'(PLANS[p].sample_check_enable));
      steady = (p == 3);
      repeat (PHASE_WORDS) present(next_event(), 1'b0, QUIET);
    end
    steady = 1'b0;
    settle();

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
